// ===== rtl/sps_pkg.sv =====
package sps_pkg;

  localparam int POSITION_BITS = 32;
  localparam int DELAY_BITS = 32;

  localparam logic [DELAY_BITS-1:0] DELAY_MAX = {DELAY_BITS{1'b1}};
  localparam logic [31:0] STEP_DELAY_RESET = 32'd2000;

  localparam int IN_DATA_BITS = 40;
  localparam int OUT_DATA_BITS = 40;
  localparam int ADDR_BITS = 4;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_SET_TARGET = 2'd1,
    OP_SINGLE     = 2'd2,
    OP_COILS_OFF  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_FULL_DOUBLE = 2'd0,
    MODE_FULL_SINGLE = 2'd1,
    MODE_HALF        = 2'd2,
    MODE_UNUSED      = 2'd3
  } mode_t;

  localparam logic [1:0] REG_STEP_MODE  = 2'd0;
  localparam logic [1:0] REG_BIPOLAR    = 2'd1;
  localparam logic [1:0] REG_STEP_DELAY = 2'd2;

  function automatic logic [3:0] full_double_coils(input logic [1:0] ph);
    logic [3:0] c;
    unique case (ph)
      2'd0: c = 4'h3;
      2'd1: c = 4'h6;
      2'd2: c = 4'hC;
      default: c = 4'h9;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] full_single_coils(input logic [1:0] ph);
    logic [3:0] c;
    unique case (ph)
      2'd0: c = 4'h1;
      2'd1: c = 4'h2;
      2'd2: c = 4'h4;
      default: c = 4'h8;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] half_coils(input logic [2:0] ph);
    logic [3:0] c;
    unique case (ph)
      3'd0: c = 4'h1;
      3'd1: c = 4'h3;
      3'd2: c = 4'h2;
      3'd3: c = 4'h6;
      3'd4: c = 4'h4;
      3'd5: c = 4'hC;
      3'd6: c = 4'h8;
      default: c = 4'h9;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] bipolar_coils(input logic [1:0] ph);
    logic [3:0] c;
    unique case (ph)
      2'd0: c = 4'h5;
      2'd1: c = 4'h6;
      2'd2: c = 4'hA;
      default: c = 4'h9;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/stepper_phase_sequencer.sv =====
// stepper phase sequencer: coil drive toward a target position
// input beat to output beat: input register, then result register
// throughput: one beat per cycle unless the output stalls; state update and table lookup sit in one register stage
// a stalled output holds its beat while one more input beat waits in the input register
// reset (rst, synchronous, active high): position, target, phase, coils cleared,
// tick count saturated, step_mode 0, bipolar_output 0, step_delay 2000
module stepper_phase_sequencer
  import sps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // apb configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_BITS-1:0]     paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  // input stream
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,  // target[31:0], direction[32], zero pad
  input  logic [1:0]               s_tuser,  // operation[1:0]
  // output stream
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata   // coils[3:0], position[35:4], moving[36],
                                             // stepped[37], zero pad
);

  // configuration registers
  logic [1:0]  step_mode;
  logic        bipolar_output;
  logic [31:0] step_delay;

  logic [1:0] reg_index;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_BITS-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_mode      <= 2'd0;
      bipolar_output <= 1'b0;
      step_delay     <= STEP_DELAY_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_STEP_MODE:  step_mode      <= pwdata[1:0];
        REG_BIPOLAR:    bipolar_output <= pwdata[0];
        REG_STEP_DELAY: step_delay     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_STEP_MODE:  prdata = {30'd0, step_mode};
      REG_BIPOLAR:    prdata = {31'd0, bipolar_output};
      REG_STEP_DELAY: prdata = step_delay;
      default:        prdata = 32'd0;
    endcase
  end

  // input register
  logic        in_valid;
  op_t         in_op;
  logic [31:0] in_target;
  logic        in_dir;
  logic        advance;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op     <= op_t'(s_tuser);
      in_target <= s_tdata[31:0];
      in_dir    <= s_tdata[32];
    end
  end

  // block state
  logic signed [POSITION_BITS-1:0] position;
  logic signed [POSITION_BITS-1:0] target_pos;
  logic [2:0]                      phase;
  logic [DELAY_BITS-1:0]           ticks;
  logic [3:0]                      coils;

  logic signed [POSITION_BITS-1:0] position_next;
  logic signed [POSITION_BITS-1:0] target_pos_next;
  logic [2:0]                      phase_next;
  logic [DELAY_BITS-1:0]           ticks_next;
  logic [3:0]                      coils_next;
  logic                            stepped;

  logic [DELAY_BITS-1:0] need;
  logic [DELAY_BITS-1:0] ticks_inc;
  logic [63:0]           delay_ext;
  logic signed [63:0]    target_ext;
  logic                  do_step;
  logic                  step_fwd;
  logic [2:0]            step_phase;
  logic [3:0]            step_coils;
  logic                  half_mode;

  assign delay_ext  = 64'(step_delay);
  assign need       = (delay_ext > 64'(DELAY_MAX)) ? DELAY_MAX : DELAY_BITS'(step_delay);
  assign ticks_inc  = (ticks != DELAY_MAX) ? ticks + DELAY_BITS'(1) : ticks;
  assign target_ext = 64'(signed'(in_target));
  assign half_mode  = (step_mode == MODE_HALF);

  always_comb begin
    if (step_fwd) begin
      step_phase = half_mode ? phase + 3'd1 : {1'b0, phase[1:0] + 2'd1};
    end else begin
      step_phase = half_mode ? phase - 3'd1 : {1'b0, phase[1:0] - 2'd1};
    end
  end

  always_comb begin
    if (bipolar_output) begin
      step_coils = bipolar_coils(step_phase[1:0]);
    end else begin
      unique case (mode_t'(step_mode))
        MODE_FULL_DOUBLE: step_coils = full_double_coils(step_phase[1:0]);
        MODE_FULL_SINGLE: step_coils = full_single_coils(step_phase[1:0]);
        MODE_HALF:        step_coils = half_coils(step_phase);
        MODE_UNUSED:      step_coils = coils;
      endcase
    end
  end

  always_comb begin
    position_next   = position;
    target_pos_next = target_pos;
    phase_next      = phase;
    ticks_next      = ticks;
    coils_next      = coils;
    do_step         = 1'b0;
    step_fwd        = in_dir;
    unique case (in_op)
      OP_TICK: begin
        ticks_next = ticks_inc;
        step_fwd   = target_pos > position;
        if (position != target_pos && ticks_inc >= need) begin
          ticks_next = '0;
          do_step    = 1'b1;
        end
      end
      OP_SET_TARGET: begin
        target_pos_next = POSITION_BITS'(target_ext);
      end
      OP_SINGLE: begin
        do_step = 1'b1;
      end
      OP_COILS_OFF: begin
        coils_next = 4'd0;
      end
    endcase
    if (do_step) begin
      phase_next    = step_phase;
      coils_next    = step_coils;
      position_next = step_fwd ? position + POSITION_BITS'(1) : position - POSITION_BITS'(1);
    end
    stepped = do_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      target_pos <= '0;
      phase      <= 3'd0;
      ticks      <= DELAY_MAX;
      coils      <= 4'd0;
    end else if (in_valid && advance) begin
      position   <= position_next;
      target_pos <= target_pos_next;
      phase      <= phase_next;
      ticks      <= ticks_next;
      coils      <= coils_next;
    end
  end

  // result register
  logic [63:0] position_ext;

  assign position_ext = 64'(unsigned'(position_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      m_tdata <= {2'b00, stepped, position_next != target_pos_next,
                  position_ext[31:0], coils_next};
    end
  end

endmodule

// ===== rtl/sps_checker.sv =====
module sps_checker
  import sps_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tready,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [OUT_DATA_BITS-1:0] m_tdata
);

  logic        out_beat;
  logic [31:0] last_pos;
  logic [31:0] beat_pos;
  logic        beat_stepped;

  assign out_beat     = m_tvalid && m_tready;
  assign beat_pos     = m_tdata[35:4];
  assign beat_stepped = m_tdata[37];

  // position of the last delivered beat, zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pos <= 32'd0;
    end else if (out_beat) begin
      last_pos <= beat_pos;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with output free");

  a_no_step_keeps_pos: assert property (@(posedge clk) disable iff (rst)
    out_beat && !beat_stepped |-> beat_pos == last_pos)
    else $error("position moved without a step");

  a_step_moves_one: assert property (@(posedge clk) disable iff (rst)
    out_beat && beat_stepped |->
      (beat_pos == last_pos + 32'd1) || (beat_pos == last_pos - 32'd1))
    else $error("step moved position by other than one");

endmodule

bind stepper_phase_sequencer sps_checker u_sps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== verif/stepper_phase_sequencer_tb.sv =====
`timescale 1ns / 1ps

module stepper_phase_sequencer_tb;
  import sps_pkg::*;

  localparam int RUN_LIMIT = 1_000_000;
  localparam logic [3:0] FULL_DOUBLE_LVL [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
  localparam logic [3:0] FULL_SINGLE_LVL [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
  localparam logic [3:0] HALF_LVL [8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
  localparam logic [3:0] BIPOLAR_LVL [4] = '{4'h5, 4'h6, 4'hA, 4'h9};

  typedef struct packed {
    logic [3:0]  coils;
    logic [31:0] position;
    logic        moving;
    logic        stepped;
  } drive_t;

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ADDR_BITS-1:0]     paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata;  // target[31:0], direction[32], zero pad
  logic [1:0]               s_tuser;  // operation[1:0]
  logic                     m_tvalid;
  logic                     m_tready;
  logic [OUT_DATA_BITS-1:0] m_tdata;  // coils[3:0], position[35:4], moving[36], stepped[37]

  // sequencer state as predicted
  logic [31:0] cur_pos;
  logic [31:0] tgt_pos;
  logic [2:0]  phase_idx;
  logic [31:0] tick_count;
  logic [3:0]  coil_lvls;
  mode_t       cfg_mode;
  logic        cfg_bipolar;
  logic [31:0] cfg_delay;

  drive_t pending_drive[$];
  int     mismatches;
  int     sink_wait;
  bit     idle_on;

  stepper_phase_sequencer u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic take_step(input bit fwd);
    int len;
    len = (cfg_mode == MODE_HALF) ? 8 : 4;
    if (fwd) begin
      phase_idx = 3'((int'(phase_idx) + 1) % len);
      cur_pos = cur_pos + 32'd1;
    end else begin
      phase_idx = 3'((int'(phase_idx) + len - 1) % len);
      cur_pos = cur_pos - 32'd1;
    end
    if (cfg_bipolar) begin
      coil_lvls = BIPOLAR_LVL[phase_idx[1:0]];
    end else begin
      case (cfg_mode)
        MODE_FULL_DOUBLE: coil_lvls = FULL_DOUBLE_LVL[phase_idx[1:0]];
        MODE_FULL_SINGLE: coil_lvls = FULL_SINGLE_LVL[phase_idx[1:0]];
        MODE_HALF: coil_lvls = HALF_LVL[phase_idx];
        default: coil_lvls = coil_lvls;
      endcase
    end
  endtask

  task automatic predict_drive(input op_t op, input logic [31:0] tgt, input logic dir);
    drive_t d;
    d.stepped = 1'b0;
    case (op)
      OP_TICK: begin
        if (tick_count != DELAY_MAX) tick_count = tick_count + 32'd1;
        if (cur_pos != tgt_pos && tick_count >= cfg_delay) begin
          tick_count = '0;
          take_step($signed(tgt_pos) > $signed(cur_pos));
          d.stepped = 1'b1;
        end
      end
      OP_SET_TARGET: tgt_pos = tgt;
      OP_SINGLE: begin
        take_step(dir);
        d.stepped = 1'b1;
      end
      default: coil_lvls = 4'h0;
    endcase
    d.coils = coil_lvls;
    d.position = cur_pos;
    d.moving = (cur_pos != tgt_pos);
    pending_drive.push_back(d);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  always @(posedge clk) begin
    drive_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        predict_drive(op_t'(s_tuser), s_tdata[31:0], s_tdata[32]);
      if (m_tvalid && m_tready) begin
        sink_wait = idle_on ? $urandom_range(0, 17) : 0;
        if (pending_drive.size() == 0) begin
          report_mismatch("unexpected beat", 32'h0, m_tdata[35:4]);
        end else begin
          want = pending_drive.pop_front();
          if (m_tdata[3:0] != want.coils)
            report_mismatch("coils", 32'(want.coils), 32'(m_tdata[3:0]));
          if (m_tdata[35:4] != want.position)
            report_mismatch("position", want.position, m_tdata[35:4]);
          if (m_tdata[36] != want.moving)
            report_mismatch("moving", 32'(want.moving), 32'(m_tdata[36]));
          if (m_tdata[37] != want.stepped)
            report_mismatch("stepped", 32'(want.stepped), 32'(m_tdata[37]));
        end
      end
    end
  end

  // output side backpressure
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst && sink_wait > 0) begin
        m_tready <= 1'b0;
        sink_wait = sink_wait - 1;
      end else begin
        m_tready <= !rst;
      end
    end
  end

  task automatic push_command(input op_t op, input logic [31:0] tgt, input logic dir);
    int gap;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {7'b0, dir, tgt};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_STEP_MODE: cfg_mode = mode_t'(val[1:0]);
      REG_BIPOLAR: cfg_bipolar = val[0];
      default: cfg_delay = val;
    endcase
  endtask

  task automatic send_random_command();
    int r;
    op_t op;
    logic [31:0] tgt;
    logic dir;
    r = $urandom_range(0, 99);
    tgt = $urandom;
    dir = 1'($urandom_range(0, 1));
    if (r < 58) begin
      op = OP_TICK;
    end else if (r < 72) begin
      op = OP_SET_TARGET;
      tgt = cur_pos + 32'($urandom_range(0, 40)) - 32'd20;
    end else if (r < 76) begin
      op = OP_SET_TARGET;
    end else if (r < 93) begin
      op = OP_SINGLE;
    end else begin
      op = OP_COILS_OFF;
    end
    push_command(op, tgt, dir);
  endtask

  // saturated count lets the first tick after a target is set step, default delay blocks the next
  task automatic test_first_tick_after_reset();
    idle_on = 1'b1;
    push_command(OP_TICK, 32'h0, 1'b0);
    push_command(OP_SET_TARGET, 32'd3, 1'b0);
    push_command(OP_TICK, 32'hFFFF_FFFF, 1'b1);
    push_command(OP_TICK, 32'h0, 1'b0);
    push_command(OP_COILS_OFF, 32'h0, 1'b0);
    push_command(OP_TICK, 32'h0, 1'b0);
    drain_results();
  endtask

  task automatic test_operations_and_extremes();
    idle_on = 1'b0;
    push_command(OP_SINGLE, 32'h0, 1'b1);
    push_command(OP_SINGLE, 32'h0, 1'b0);
    push_command(OP_SINGLE, 32'h0, 1'b0);
    push_command(OP_SINGLE, 32'h0, 1'b0);
    push_command(OP_SET_TARGET, 32'h7FFF_FFFF, 1'b1);
    push_command(OP_SET_TARGET, 32'hFFFF_FFFF, 1'b0);
    push_command(OP_SET_TARGET, 32'h8000_0000, 1'b0);
    drain_results();
    write_reg(REG_STEP_DELAY, 32'h0);
    push_command(OP_TICK, 32'h0, 1'b0);
    push_command(OP_TICK, 32'h0, 1'b0);
    push_command(OP_SET_TARGET, 32'h7FFF_FFFF, 1'b0);
    push_command(OP_TICK, 32'h0, 1'b0);
    push_command(OP_TICK, 32'h0, 1'b0);
    drain_results();
    write_reg(REG_STEP_MODE, {30'b0, MODE_HALF});
    push_command(OP_SINGLE, 32'h0, 1'b1);
    push_command(OP_SINGLE, 32'h0, 1'b1);
    drain_results();
    write_reg(REG_BIPOLAR, 32'h1);
    push_command(OP_SINGLE, 32'h0, 1'b1);
    drain_results();
    write_reg(REG_BIPOLAR, 32'h0);
    write_reg(REG_STEP_MODE, {30'b0, MODE_UNUSED});
    push_command(OP_SINGLE, 32'h0, 1'b1);
    push_command(OP_COILS_OFF, 32'h0, 1'b1);
    push_command(OP_SINGLE, 32'h0, 1'b0);
    drain_results();
  endtask

  // mode, bipolar and delay changes with the phase index carried over
  task automatic test_mode_sweep();
    logic [31:0] dly;
    for (int p = 0; p < 16; p++) begin
      case (p)
        0: dly = 32'd1;
        3: dly = 32'hFFFF_FFFF;
        5: dly = 32'd0;
        9: dly = STEP_DELAY_RESET;
        default: dly = 32'($urandom_range(1, 8));
      endcase
      write_reg(REG_STEP_MODE, 32'(p % 4));
      write_reg(REG_BIPOLAR, 32'((p / 4) % 2));
      write_reg(REG_STEP_DELAY, dly);
      idle_on = (p % 3 != 2);
      repeat (95) send_random_command();
      drain_results();
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_TICK;
    mismatches = 0;
    sink_wait = 0;
    idle_on = 1'b1;
    cur_pos = '0;
    tgt_pos = '0;
    phase_idx = '0;
    tick_count = DELAY_MAX;
    coil_lvls = 4'h0;
    cfg_mode = MODE_FULL_DOUBLE;
    cfg_bipolar = 1'b0;
    cfg_delay = STEP_DELAY_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_first_tick_after_reset();
    test_operations_and_extremes();
    test_mode_sweep();

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_drive.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
